/* sv/fix_message_framer_macros.svh */
// ---------------------------------------------------------------------------
// FIX message framer assertion macros
// Shorthand for the concurrent checks of the framer, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef FIX_MESSAGE_FRAMER_MACROS_SVH
`define FIX_MESSAGE_FRAMER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define FMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fmf_pkg.sv */
// ---------------------------------------------------------------------------
// FIX message framer package
// Shared constants, header walker types and decimal helpers.
// ---------------------------------------------------------------------------
package fmf_pkg;

  localparam int unsigned BODY_DEPTH_DEF = 1024;
  localparam int unsigned HDR_MAX        = 128;
  localparam int unsigned HLEN_W         = 7;
  localparam int unsigned SEQ_W          = 32;
  localparam int unsigned SEQ_DIGITS     = 10;
  localparam int unsigned YEAR_W         = 14;
  localparam int unsigned YEAR_DIGITS    = 5;
  localparam int unsigned PADDR_W        = 5;
  localparam int unsigned PDATA_W        = 64;

  localparam logic [3:0] ID_CHARS = 4'd8;
  localparam logic [7:0] SOH      = 8'h01;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_SEQ_RST = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEG_PREFIX,
    SEG_TYPE,
    SEG_SEQ,
    SEG_SNDR,
    SEG_TIME,
    SEG_TRGT
  } seg_e;

  typedef struct packed {
    seg_e       seg;
    logic [4:0] off;
  } walk_t;

  typedef struct packed {
    logic [15:0]                 mtype;
    logic [SEQ_DIGITS-1:0][3:0]  seq_dig;
    logic [3:0]                  seq_nd;
    logic [63:0]                 snd_id;
    logic [3:0]                  snd_n;
    logic [63:0]                 tgt_id;
    logic [3:0]                  tgt_n;
    logic [3:0][3:0]             yr_dig;
    logic [5:0]                  mon;
    logic [5:0]                  day;
    logic [5:0]                  hour;
    logic [5:0]                  minute;
    logic [5:0]                  sec;
    logic [2:0][3:0]             len_dig;
  } hdr_info_t;

  typedef struct packed {
    logic [63:0] snd_id;
    logic [3:0]  snd_len;
    logic [63:0] tgt_id;
    logic [3:0]  tgt_len;
  } cfg_t;

  // ASCII digit of a BCD nibble
  function automatic logic [7:0] asc(input logic [3:0] d);
    return {4'h3, d};
  endfunction

  // Two ASCII digits of a value below 64; tens by reciprocal multiply
  function automatic logic [15:0] dec2(input logic [5:0] v);
    logic [13:0] p;
    logic [3:0]  t;
    logic [5:0]  u;
    p = 14'(v) * 14'd205;
    t = {1'b0, p[13:11]};
    u = v - ({2'b00, t} * 6'd10);
    return {asc(t), asc(u[3:0])};
  endfunction

endpackage

/* sv/fmf_if.sv */
// ---------------------------------------------------------------------------
// FIX message framer channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface fmf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  body_byte;
  logic        has_byte;
  logic        body_last;
  logic [7:0]  type_first;
  logic [7:0]  type_second;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, operation, body_byte, has_byte, body_last, type_first,
                  type_second, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, operation, body_byte, has_byte, body_last, type_first,
                  type_second, year, month, day, hour, minute, second, output ready);
endinterface

interface fmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       overflow;

  modport source (output valid, out_byte, out_valid, out_last, overflow, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, overflow, output ready);
endinterface

/* sv/fix_message_framer.sv */
// A pull's result is registered: a header or trailer byte goes straight into the result
// register, a body byte passes the body memory read register first; a push has no result.
// Pushes and other items without a result are taken one per cycle while no result is
// pending and no conversion runs; a pull waits until the result register has drained.
// The last push of a message holds the input through sequence number conversion, the
// header pass over each header byte (up to 85) and the decimal digit steps.
// Reset: asynchronous, active low; sequence number 1, body empty, memory not cleared.
// ---------------------------------------------------------------------------
// FIX message framer
// Collects a message body, then emits the framed FIX 4.4 message byte by byte.
// ---------------------------------------------------------------------------
`include "fix_message_framer_macros.svh"

module fix_message_framer #(
  parameter int unsigned BODY_DEPTH = fmf_pkg::BODY_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fmf_in_if.sink                        in_i,
  fmf_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmf_pkg::PADDR_W-1:0]   paddr,
  input  logic [fmf_pkg::PDATA_W-1:0]   pwdata,
  output logic [fmf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import fmf_pkg::*;

  localparam int unsigned AW  = $clog2(BODY_DEPTH);
  localparam int unsigned CW  = $clog2(BODY_DEPTH + 1);
  localparam int unsigned VWN = $clog2(BODY_DEPTH + HDR_MAX);
  localparam int unsigned VW  = (VWN > 10) ? VWN : 10;

  // Control sequencer: ready for items, number conversion, header pass
  // (length and sum), decimal digit steps, body memory fetch.
  typedef enum logic [2:0] {
    S_READY, S_CONV, S_PASS, S_DK, S_DH, S_DT, S_FETCH
  } st_e;

  // Position in the frame being emitted
  typedef enum logic [1:0] {
    PH_IDLE, PH_HDR, PH_BODY, PH_TRL
  } ph_e;

  st_e              st_q;
  ph_e              ph_q;
  logic [CW-1:0]    cnt_q, pos_q;
  logic [7:0]       rsum_q, hsum_q;
  logic             ovf_q;
  logic [SEQ_W-1:0] seq_q;
  logic [15:0]      mtype_q;
  logic [3:0]       mon_q;
  logic [4:0]       day_q, hour_q;
  logic [5:0]       min_q, sec_q;
  walk_t            walk_q;
  logic [HLEN_W-1:0] hlen_q;
  logic [VW-1:0]    v_q;
  logic [3:0]       dh_q, dt_q;
  logic             ck_sel_q;
  logic [2:0][3:0]  len_dig_q, ck_dig_q;

  logic             ovld_q, ovalid_q, olast_q, oovf_q;
  logic [7:0]       obyte_q;

  cfg_t             cfg;
  hdr_info_t        info;
  walk_t            walk_nx;
  logic [7:0]       hchr, body_rd, wbyte, sum_d;
  logic             hend, accept, mem_we, mem_re, conv_start;
  logic             seq_busy, yr_busy;
  logic [SEQ_DIGITS-1:0][3:0]  seq_dig;
  logic [YEAR_DIGITS-1:0][3:0] yr_dig;
  logic [3:0]       seq_nd;
  op_e              op;

  fmf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  fmf_body_mem #(.DEPTH(BODY_DEPTH)) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wbyte),
    .re_i    (mem_re),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (body_rd)
  );

  fmf_bcd #(.W(SEQ_W), .D(SEQ_DIGITS)) u_seq_bcd (
    .clk_i, .rst_ni,
    .start_i (conv_start),
    .bin_i   (seq_q),
    .busy_o  (seq_busy),
    .dig_o   (seq_dig)
  );

  fmf_bcd #(.W(YEAR_W), .D(YEAR_DIGITS)) u_yr_bcd (
    .clk_i, .rst_ni,
    .start_i (conv_start),
    .bin_i   (in_i.year),
    .busy_o  (yr_busy),
    .dig_o   (yr_dig)
  );

  fmf_hdr_gen u_gen (
    .walk_i (walk_q),
    .info_i (info),
    .chr_o  (hchr),
    .next_o (walk_nx),
    .end_o  (hend)
  );

  // Number of sequence digits: highest non-zero digit, at least one
  always_comb begin
    seq_nd = 4'd1;
    for (int i = 0; i < SEQ_DIGITS; i++) begin
      if (seq_dig[i] != 4'd0) seq_nd = 4'(i + 1);
    end
  end

  always_comb begin
    info.mtype   = mtype_q;
    info.seq_dig = seq_dig;
    info.seq_nd  = seq_nd;
    info.snd_id  = cfg.snd_id;
    info.snd_n   = (cfg.snd_len > ID_CHARS) ? ID_CHARS : cfg.snd_len;
    info.tgt_id  = cfg.tgt_id;
    info.tgt_n   = (cfg.tgt_len > ID_CHARS) ? ID_CHARS : cfg.tgt_len;
    info.yr_dig  = yr_dig[3:0];
    info.mon     = {2'b00, mon_q};
    info.day     = {1'b0, day_q};
    info.hour    = {1'b0, hour_q};
    info.minute  = min_q;
    info.sec     = sec_q;
    info.len_dig = len_dig_q;
  end

  assign in_i.ready = (st_q == S_READY) && !ovld_q;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.operation);
  assign wbyte      = (in_i.body_byte == 8'd0) ? SOH : in_i.body_byte;

  // Body writes only while collecting, body reads only while framing, so the
  // memory never sees both on the same entry.
  assign mem_we = accept && (op == OP_PUSH) && (ph_q == PH_IDLE) && in_i.has_byte
                  && (cnt_q < CW'(BODY_DEPTH));
  assign mem_re = accept && (op == OP_PULL) && (ph_q == PH_BODY);
  assign conv_start = accept && (op == OP_PUSH) && (ph_q == PH_IDLE) && in_i.body_last;

  // Header sum plus the three length digits
  assign sum_d = hsum_q + 8'd144 + {4'd0, dh_q} + {4'd0, dt_q} + {4'd0, v_q[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_READY;
      ph_q      <= PH_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      rsum_q    <= '0;
      hsum_q    <= '0;
      ovf_q     <= 1'b0;
      seq_q     <= SEQ_W'(1);
      mtype_q   <= '0;
      mon_q     <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      walk_q    <= '{seg: SEG_PREFIX, off: 5'd0};
      hlen_q    <= '0;
      v_q       <= '0;
      dh_q      <= '0;
      dt_q      <= '0;
      ck_sel_q  <= 1'b0;
      len_dig_q <= '0;
      ck_dig_q  <= '0;
      ovld_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      olast_q   <= 1'b0;
      oovf_q    <= 1'b0;
      obyte_q   <= '0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        ovld_q <= 1'b0;
      end
      unique case (st_q)
        S_READY: begin
          if (accept) begin
            case (op)
              OP_PUSH: begin
                // drop the whole push while a frame is out
                if (ph_q == PH_IDLE) begin
                  if (in_i.has_byte) begin
                    if (mem_we) begin
                      cnt_q  <= cnt_q + CW'(1);
                      rsum_q <= rsum_q + wbyte;
                    end else begin
                      ovf_q <= 1'b1;
                    end
                  end
                  if (in_i.body_last) begin
                    mtype_q <= {in_i.type_second, in_i.type_first};
                    mon_q   <= in_i.month;
                    day_q   <= in_i.day;
                    hour_q  <= in_i.hour;
                    min_q   <= in_i.minute;
                    sec_q   <= in_i.second;
                    seq_q   <= (seq_q == '1) ? SEQ_W'(1) : seq_q + SEQ_W'(1);
                    st_q    <= S_CONV;
                  end
                end
              end
              OP_SEQ_RST: begin
                seq_q <= SEQ_W'(1);
              end
              OP_PULL: begin
                oovf_q   <= ovf_q;
                ovalid_q <= (ph_q != PH_IDLE);
                olast_q  <= (ph_q == PH_TRL) && (pos_q[2:0] == 3'd6);
                // hold the result until the memory read returns
                ovld_q   <= (ph_q != PH_BODY);
                unique case (ph_q)
                  PH_IDLE: begin
                    obyte_q  <= '0;
                  end
                  PH_HDR: begin
                    obyte_q <= hchr;
                    walk_q  <= walk_nx;
                    if (hend) begin
                      pos_q <= '0;
                      ph_q  <= (cnt_q != '0) ? PH_BODY : PH_TRL;
                    end
                  end
                  PH_BODY: begin
                    st_q   <= S_FETCH;
                    if ((pos_q + CW'(1)) >= cnt_q) begin
                      pos_q <= '0;
                      ph_q  <= PH_TRL;
                    end else begin
                      pos_q <= pos_q + CW'(1);
                    end
                  end
                  PH_TRL: begin
                    case (pos_q[2:0])
                      3'd0:    obyte_q <= "1";
                      3'd1:    obyte_q <= "0";
                      3'd2:    obyte_q <= "=";
                      3'd3:    obyte_q <= asc(ck_dig_q[2]);
                      3'd4:    obyte_q <= asc(ck_dig_q[1]);
                      3'd5:    obyte_q <= asc(ck_dig_q[0]);
                      default: obyte_q <= SOH;
                    endcase
                    if (pos_q[2:0] == 3'd6) begin
                      // closing SOH: release the frame and empty the body
                      ph_q    <= PH_IDLE;
                      pos_q   <= '0;
                      cnt_q   <= '0;
                      rsum_q  <= '0;
                      ovf_q   <= 1'b0;
                    end else begin
                      pos_q <= pos_q + CW'(1);
                    end
                  end
                endcase
              end
              default: begin
              end
            endcase
          end
        end
        S_CONV: begin
          if (!seq_busy && !yr_busy) begin
            walk_q <= '{seg: SEG_PREFIX, off: 5'd0};
            hlen_q <= '0;
            hsum_q <= rsum_q;
            st_q   <= S_PASS;
          end
        end
        S_PASS: begin
          // count header bytes and sum all but the length digits
          if (!(walk_q.seg == SEG_PREFIX && walk_q.off >= 5'd12 && walk_q.off <= 5'd14)) begin
            hsum_q <= hsum_q + hchr;
          end
          hlen_q <= hlen_q + HLEN_W'(1);
          walk_q <= walk_nx;
          if (hend) begin
            v_q      <= VW'(hlen_q) + VW'(1) - VW'(16) + VW'(cnt_q);
            dh_q     <= '0;
            dt_q     <= '0;
            ck_sel_q <= 1'b0;
            st_q     <= S_DK;
          end
        end
        S_DK: begin
          if (v_q >= VW'(1000)) v_q <= v_q - VW'(1000);
          else st_q <= S_DH;
        end
        S_DH: begin
          if (v_q >= VW'(100)) begin
            v_q  <= v_q - VW'(100);
            dh_q <= dh_q + 4'd1;
          end else begin
            st_q <= S_DT;
          end
        end
        S_DT: begin
          if (v_q >= VW'(10)) begin
            v_q  <= v_q - VW'(10);
            dt_q <= dt_q + 4'd1;
          end else if (!ck_sel_q) begin
            // length done: fold its digits into the checksum, then split that
            len_dig_q <= {dh_q, dt_q, v_q[3:0]};
            hsum_q    <= sum_d;
            v_q       <= VW'(sum_d);
            dh_q      <= '0;
            dt_q      <= '0;
            ck_sel_q  <= 1'b1;
            st_q      <= S_DK;
          end else begin
            ck_dig_q <= {dh_q, dt_q, v_q[3:0]};
            walk_q   <= '{seg: SEG_PREFIX, off: 5'd0};
            ph_q     <= PH_HDR;
            st_q     <= S_READY;
          end
        end
        S_FETCH: begin
          obyte_q  <= body_rd;
          ovalid_q <= 1'b1;
          olast_q  <= 1'b0;
          ovld_q   <= 1'b1;
          st_q     <= S_READY;
        end
        default: st_q <= S_READY;
      endcase
    end
  end

  assign out_o.valid     = ovld_q;
  assign out_o.out_byte  = obyte_q;
  assign out_o.out_valid = ovalid_q;
  assign out_o.out_last  = olast_q;
  assign out_o.overflow  = oovf_q;

  `FMF_ASSERT_NOW(a_wr_idle, mem_we, ph_q == PH_IDLE, "body write while framing")
  `FMF_ASSERT_NOW(a_cnt_rng, 1'b1, cnt_q <= CW'(BODY_DEPTH), "body count past depth")
  `FMF_ASSERT_NEXT(a_fetch_out, st_q == S_FETCH, ovld_q, "fetched body byte not shown")
  `FMF_ASSERT_NOW(a_last_idle, ovld_q && olast_q, ph_q == PH_IDLE, "frame open after last")

endmodule

/* sv/fmf_body_mem.sv */
// ---------------------------------------------------------------------------
// FIX framer body memory
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module fmf_body_mem #(
  parameter int unsigned DEPTH = fmf_pkg::BODY_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/fmf_bcd.sv */
// ---------------------------------------------------------------------------
// FIX framer binary to BCD converter
// Shift-and-add-3, one input bit per cycle.
// ---------------------------------------------------------------------------
module fmf_bcd #(
  parameter int unsigned W = fmf_pkg::SEQ_W,
  parameter int unsigned D = fmf_pkg::SEQ_DIGITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        bin_i,
  output logic                busy_o,
  output logic [D-1:0][3:0]   dig_o
);
  localparam int unsigned CNTW = $clog2(W + 1);

  logic [W-1:0]      sh_q;
  logic [D-1:0][3:0] dig_q, adj;
  logic [CNTW-1:0]   cnt_q;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sh_q  <= '0;
      dig_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(W);
      sh_q  <= bin_i;
      dig_q <= '0;
    end else if (cnt_q != '0) begin
      // shift the adjusted digits up, feed the next input bit
      for (int i = 0; i < D; i++) begin
        dig_q[i] <= {adj[i][2:0], (i == 0) ? sh_q[W-1] : adj[(i == 0) ? 0 : i-1][3]};
      end
      sh_q  <= sh_q << 1;
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign dig_o  = dig_q;
endmodule

/* sv/fmf_hdr_gen.sv */
// ---------------------------------------------------------------------------
// FIX framer header byte generator
// Byte at a segment/offset position and the position after it.
// ---------------------------------------------------------------------------
module fmf_hdr_gen (
  input  fmf_pkg::walk_t     walk_i,
  input  fmf_pkg::hdr_info_t info_i,
  output logic [7:0]         chr_o,
  output fmf_pkg::walk_t     next_o,
  output logic               end_o
);
  import fmf_pkg::*;

  logic [4:0]  off, rel, sidx, yidx;
  logic        seg_last;
  logic [7:0]  tag_a, tag_b;
  logic [15:0] mon_c, day_c, hour_c, min_c, sec_c;
  seg_e        seg_nx;

  assign off    = walk_i.off;
  assign rel    = off - 5'd3;
  assign sidx   = {1'b0, info_i.seq_nd} - 5'd1 - rel;
  assign yidx   = 5'd6 - off;
  assign mon_c  = dec2(info_i.mon);
  assign day_c  = dec2(info_i.day);
  assign hour_c = dec2(info_i.hour);
  assign min_c  = dec2(info_i.minute);
  assign sec_c  = dec2(info_i.sec);

  always_comb begin
    chr_o    = SOH;
    seg_last = 1'b0;
    tag_a    = "3";
    tag_b    = "5";
    seg_nx   = SEG_TYPE;
    unique case (walk_i.seg)
      SEG_PREFIX: begin
        seg_last = (off == 5'd15);
        seg_nx   = SEG_TYPE;
        case (off)
          5'd0:    chr_o = "8";
          5'd1:    chr_o = "=";
          5'd2:    chr_o = "F";
          5'd3:    chr_o = "I";
          5'd4:    chr_o = "X";
          5'd5:    chr_o = ".";
          5'd6:    chr_o = "4";
          5'd7:    chr_o = ".";
          5'd8:    chr_o = "4";
          5'd10:   chr_o = "9";
          5'd11:   chr_o = "=";
          5'd12:   chr_o = asc(info_i.len_dig[2]);
          5'd13:   chr_o = asc(info_i.len_dig[1]);
          5'd14:   chr_o = asc(info_i.len_dig[0]);
          default: chr_o = SOH;
        endcase
      end
      SEG_TYPE: begin
        seg_last = (off == ((info_i.mtype[15:8] != 8'd0) ? 5'd5 : 5'd4));
        seg_nx   = SEG_SEQ;
        if (off == 5'd3) begin
          chr_o = info_i.mtype[7:0];
        end else if (off == 5'd4 && info_i.mtype[15:8] != 8'd0) begin
          chr_o = info_i.mtype[15:8];
        end
      end
      SEG_SEQ: begin
        tag_b    = "4";
        seg_last = (off == 5'({1'b0, info_i.seq_nd} + 5'd3));
        seg_nx   = (info_i.snd_n != 4'd0) ? SEG_SNDR : SEG_TIME;
        if (off >= 5'd3 && rel < 5'({1'b0, info_i.seq_nd})) begin
          chr_o = asc(info_i.seq_dig[sidx[3:0]]);
        end
      end
      SEG_SNDR: begin
        tag_a    = "4";
        tag_b    = "9";
        seg_last = (off == 5'({1'b0, info_i.snd_n} + 5'd3));
        seg_nx   = SEG_TIME;
        if (off >= 5'd3 && rel < 5'({1'b0, info_i.snd_n})) begin
          chr_o = info_i.snd_id[{rel[2:0], 3'b000} +: 8];
        end
      end
      SEG_TIME: begin
        tag_a    = "5";
        tag_b    = "2";
        seg_last = (off == 5'd24);
        seg_nx   = SEG_TRGT;
        case (off)
          5'd3, 5'd4, 5'd5, 5'd6: chr_o = asc(info_i.yr_dig[yidx[1:0]]);
          5'd7:    chr_o = mon_c[15:8];
          5'd8:    chr_o = mon_c[7:0];
          5'd9:    chr_o = day_c[15:8];
          5'd10:   chr_o = day_c[7:0];
          5'd11:   chr_o = "-";
          5'd12:   chr_o = hour_c[15:8];
          5'd13:   chr_o = hour_c[7:0];
          5'd14:   chr_o = ":";
          5'd15:   chr_o = min_c[15:8];
          5'd16:   chr_o = min_c[7:0];
          5'd17:   chr_o = ":";
          5'd18:   chr_o = sec_c[15:8];
          5'd19:   chr_o = sec_c[7:0];
          5'd20:   chr_o = ".";
          5'd21, 5'd22, 5'd23: chr_o = "0";
          default: chr_o = SOH;
        endcase
      end
      SEG_TRGT: begin
        tag_b    = "6";
        tag_a    = "5";
        seg_last = (off == 5'({1'b0, info_i.tgt_n} + 5'd3));
        seg_nx   = SEG_PREFIX;
        if (off >= 5'd3 && rel < 5'({1'b0, info_i.tgt_n})) begin
          chr_o = info_i.tgt_id[{rel[2:0], 3'b000} +: 8];
        end
      end
      default: begin
        seg_last = 1'b1;
        seg_nx   = SEG_PREFIX;
      end
    endcase
    // tag and '=' open every segment but the prefix
    if (walk_i.seg != SEG_PREFIX) begin
      if (off == 5'd0) chr_o = tag_a;
      else if (off == 5'd1) chr_o = tag_b;
      else if (off == 5'd2) chr_o = "=";
    end
  end

  always_comb begin
    next_o.seg = seg_last ? seg_nx : walk_i.seg;
    next_o.off = seg_last ? 5'd0 : off + 5'd1;
    end_o      = seg_last && (walk_i.seg == SEG_TRGT);
  end
endmodule

/* sv/fmf_cfg.sv */
// ---------------------------------------------------------------------------
// FIX framer configuration registers
// APB-style register file for the sender and target ids.
// ---------------------------------------------------------------------------
module fmf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmf_pkg::PADDR_W-1:0]   paddr,
  input  logic [fmf_pkg::PDATA_W-1:0]   pwdata,
  output logic [fmf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output fmf_pkg::cfg_t                 cfg_o
);
  import fmf_pkg::*;

  typedef enum logic [1:0] {
    REG_SND_ID  = 2'd0,
    REG_SND_LEN = 2'd1,
    REG_TGT_ID  = 2'd2,
    REG_TGT_LEN = 2'd3
  } reg_e;

  cfg_t cfg_q;
  reg_e idx;

  assign idx    = reg_e'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SND_ID:  cfg_q.snd_id  <= pwdata;
        REG_SND_LEN: cfg_q.snd_len <= pwdata[3:0];
        REG_TGT_ID:  cfg_q.tgt_id  <= pwdata;
        REG_TGT_LEN: cfg_q.tgt_len <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SND_ID:  prdata = cfg_q.snd_id;
      REG_SND_LEN: prdata = {60'd0, cfg_q.snd_len};
      REG_TGT_ID:  prdata = cfg_q.tgt_id;
      REG_TGT_LEN: prdata = {60'd0, cfg_q.tgt_len};
    endcase
  end

  assign cfg_o = cfg_q;
endmodule
